/* sv/brf_pkg.sv */
`default_nettype none

package brf_pkg;

   // Frame and ring geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int RING_DEPTH = 8192;
   localparam int OFFSET     = 4;

   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam int W_W     = 11;
   localparam int H_W     = 13;
   localparam int CNT_W   = 23;
   localparam int OFS_W   = $clog2(OFFSET + 1);
   localparam int CSR_IW  = 1;
   localparam int CSR_DW  = 13;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   typedef enum logic [CSR_IW-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_last;
   } rsp_payload_type;

   // Issue information passed from the control logic to the output stage
   typedef struct packed {
      logic      emit;
      logic      last;
      logic      fwd1;
      logic      fwd2;
      pixel_type fwd_pixel;
   } emit_issue_type;

endpackage

`default_nettype wire

/* sv/brf_ring_ram.sv */
`default_nettype none

module brf_ring_ram
   import brf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [RING_AW-1:0] wr_addr,
   input  wire pixel_type          wr_data,
   input  wire logic               rd_en,
   input  wire logic [RING_AW-1:0] rd_addr1,
   input  wire logic [RING_AW-1:0] rd_addr2,
   output pixel_type               rd_data1,
   output pixel_type               rd_data2
);

   pixel_type ring_mem_ff [RING_DEPTH];
   pixel_type rd_data1_ff;
   pixel_type rd_data2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data1_ff <= ring_mem_ff[rd_addr1];
         rd_data2_ff <= ring_mem_ff[rd_addr2];
      end
   end

   assign rd_data1 = rd_data1_ff;
   assign rd_data2 = rd_data2_ff;

endmodule

`default_nettype wire

/* sv/brf_pos_divider.sv */
`default_nettype none

module brf_pos_divider
   import brf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CNT_W-1:0] dividend,
   input  wire logic [W_W-1:0]   divisor,
   output logic                  busy,
   output logic                  done,
   output logic [H_W-1:0]        quotient,
   output logic [W_W-1:0]        remainder
);

   localparam int STEP_CW = $clog2(CNT_W + 1);

   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [STEP_CW-1:0] step_ff,  step_in;
   logic [CNT_W-1:0]   dvd_ff,   dvd_in;
   logic [CNT_W-1:0]   quo_ff,   quo_in;
   logic [W_W:0]       rem_ff,   rem_in;
   logic [W_W:0]       rem_shift;
   logic               fits;

   // One restoring step a cycle, most significant dividend bit first
   always_comb begin
      rem_shift = {rem_ff[W_W-1:0], dvd_ff[CNT_W-1]};
      fits      = rem_shift >= {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_CW'(CNT_W);
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[CNT_W-2:0], 1'b0};
         quo_in  = {quo_ff[CNT_W-2:0], fits};
         rem_in  = fits ? (rem_shift - {1'b0, divisor}) : rem_shift;
         step_in = step_ff - STEP_CW'(1);
         if (step_ff == STEP_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff | done_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff[H_W-1:0];
   assign remainder = rem_ff[W_W-1:0];

endmodule

`default_nettype wire

/* sv/brf_output_stage.sv */
`default_nettype none

module brf_output_stage
   import brf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            issue_en,
   input  wire emit_issue_type  issue,
   input  wire pixel_type       rd_data1,
   input  wire pixel_type       rd_data2,
   output logic                 stage_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   function automatic logic [7:0] emboss(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, ~a} + {1'b0, b};
      return sum[8:1];
   endfunction

   emit_issue_type  stage_ff;
   logic            stage_valid_ff, stage_valid_in;
   logic            rsp_valid_ff,   rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            out_load;
   pixel_type       p1;
   pixel_type       p2;

   assign out_load    = !rsp_valid_ff || rsp_ready;
   assign stage_ready = !stage_valid_ff || out_load;

   // Use the pixel written alongside the read where the addresses matched
   always_comb begin
      p1 = stage_ff.fwd1 ? stage_ff.fwd_pixel : rd_data1;
      p2 = stage_ff.fwd2 ? stage_ff.fwd_pixel : rd_data2;
      rsp_payload_in.out_red    = emboss(p1.red,   p2.red);
      rsp_payload_in.out_green  = emboss(p1.green, p2.green);
      rsp_payload_in.out_blue   = emboss(p1.blue,  p2.blue);
      rsp_payload_in.out_alpha  = emboss(p1.alpha, p2.alpha);
      rsp_payload_in.frame_last = stage_ff.last;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (issue_en) begin
         stage_valid_in = issue.emit;
      end else if (out_load) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = out_load ? stage_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_en) begin
         stage_ff <= issue;
      end
      if (out_load && stage_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* sv/bas_relief_emboss_filter_unit.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_payload_type (op, in_red..in_alpha)
// rsp      out        rsp_valid/rsp_ready  rsp_payload_type (out_red..out_alpha, frame_last)
// csr      in         csr_we               csr_index, csr_wdata (write only)
//
// One item is taken per cycle unless the divider or the read stage holds the input; a result
// passes the registered read of the two-read-port ring memory and then the output register.
// Reset is synchronous; the ring store is not cleared, only counters and registers.
// After each register write the input stalls while a serial divider works out the column
// and row of the next output for the new width.
// A stalled result holds in the output register while the next one waits in the read stage.
`default_nettype none

module bas_relief_emboss_filter_unit
   import brf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_payload_type   req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   localparam int PROD_W = W_W + H_W;

   // Configuration and derived frame sizes
   logic [W_W-1:0]    width_ff,  width_in;
   logic [H_W-1:0]    height_ff, height_in;
   logic [W_W-1:0]    w_eff;
   logic [H_W-1:0]    h_eff;
   logic [PROD_W-1:0] total_full;
   logic [CNT_W-1:0]  total_ff;
   logic [CNT_W-1:0]  offw_ff;

   // Frame counters and output position
   logic [CNT_W-1:0]  recv_ff, recv_in;
   logic [CNT_W-1:0]  emit_ff, emit_in;
   logic [W_W-1:0]    col_ff,  col_in;
   logic [H_W-1:0]    row_ff,  row_in;

   // Step decode
   logic              accept;
   logic              is_pixel;
   logic              recv_open;
   logic              emit_open;
   logic              store;
   logic              do_emit;
   logic              drain_clear;
   logic              last;
   logic [CNT_W-1:0]  emit_next;

   // Ring addressing
   logic [W_W-1:0]     dx;
   logic [W_W-1:0]     dx_sel;
   logic [H_W-1:0]     dy;
   logic [OFS_W-1:0]   dy_sel;
   logic [RING_AW-1:0] dyw;
   logic [RING_AW-1:0] rd_addr1;
   logic [RING_AW-1:0] rd_addr2;
   logic [RING_AW-1:0] wr_addr;
   pixel_type          wr_pixel;
   pixel_type          rd_data1;
   pixel_type          rd_data2;
   emit_issue_type     issue;

   // Divider and output stage handshakes
   logic              div_busy;
   logic              div_done;
   logic [H_W-1:0]    div_quo;
   logic [W_W-1:0]    div_rem;
   logic              stage_ready;

   // Register writes: take the value at once, the derived sizes follow in the cycle after
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[W_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[H_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   // Zero width or height reads as one; width saturates at the widest line
   always_comb begin
      if (width_ff == '0) begin
         w_eff = W_W'(1);
      end else if (width_ff > W_W'(MAX_WIDTH)) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff      = (height_ff == '0) ? H_W'(1) : height_ff;
      total_full = PROD_W'(w_eff) * PROD_W'(h_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= W_W'(RESET_WIDTH);
         height_ff <= H_W'(RESET_HEIGHT);
         total_ff  <= CNT_W'(RESET_WIDTH * RESET_HEIGHT);
         offw_ff   <= CNT_W'(RESET_WIDTH * OFFSET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_full[CNT_W-1:0];
         offw_ff   <= CNT_W'(w_eff) * CNT_W'(OFFSET);
      end
   end

   // Decode the step against the frame counters
   always_comb begin
      accept      = req_valid && req_ready;
      is_pixel    = req_payload.op == OP_PIXEL;
      recv_open   = recv_ff < total_ff;
      emit_open   = emit_ff < total_ff;
      store       = is_pixel && recv_open;
      do_emit     = is_pixel ? (recv_open && (recv_ff >= offw_ff) && emit_open)
                             : (!recv_open && emit_open);
      drain_clear = !is_pixel && !recv_open && !emit_open;
      emit_next   = emit_ff + CNT_W'(1);
      last        = emit_next >= total_ff;
   end

   // Both taps sit ahead of the current output: one along the line, one down the column.
   // Each offset clamps at the frame edge.
   always_comb begin
      dx       = w_eff - W_W'(1) - col_ff;
      dx_sel   = (dx >= W_W'(OFFSET)) ? W_W'(OFFSET) : dx;
      dy       = h_eff - H_W'(1) - row_ff;
      dy_sel   = (dy >= H_W'(OFFSET)) ? OFS_W'(OFFSET) : dy[OFS_W-1:0];
      dyw      = RING_AW'(dy_sel) * RING_AW'(w_eff);
      rd_addr1 = emit_ff[RING_AW-1:0] + RING_AW'(dx_sel);
      rd_addr2 = emit_ff[RING_AW-1:0] + dyw;
      wr_addr  = recv_ff[RING_AW-1:0];
      wr_pixel.red   = req_payload.in_red;
      wr_pixel.green = req_payload.in_green;
      wr_pixel.blue  = req_payload.in_blue;
      wr_pixel.alpha = req_payload.in_alpha;
      // The memory returns the old entry when it is written in the same cycle:
      // forward the incoming pixel instead
      issue.emit      = do_emit;
      issue.last      = last;
      issue.fwd1      = store && (rd_addr1 == wr_addr);
      issue.fwd2      = store && (rd_addr2 == wr_addr);
      issue.fwd_pixel = wr_pixel;
   end

   // Counter update: advance on a transfer, reload the position when the divider ends
   always_comb begin
      recv_in = recv_ff;
      emit_in = emit_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (div_done) begin
         col_in = div_rem;
         row_in = div_quo;
      end else if (accept) begin
         if (store) begin
            recv_in = recv_ff + CNT_W'(1);
         end
         if (drain_clear || (do_emit && last)) begin
            recv_in = '0;
            emit_in = '0;
            col_in  = '0;
            row_in  = '0;
         end else if (do_emit) begin
            emit_in = emit_next;
            if (col_ff == w_eff - W_W'(1)) begin
               col_in = '0;
               row_in = row_ff + H_W'(1);
            end else begin
               col_in = col_ff + W_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff <= '0;
         emit_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         recv_ff <= recv_in;
         emit_ff <= emit_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // Hold input while the position is recomputed or the read stage cannot move
   assign req_ready = !div_busy && stage_ready;

   brf_pos_divider u_pos_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (csr_we),
      .dividend  (emit_ff),
      .divisor   (w_eff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   brf_ring_ram u_ring_ram (
      .clock    (clock),
      .wr_en    (accept && store),
      .wr_addr  (wr_addr),
      .wr_data  (wr_pixel),
      .rd_en    (accept && do_emit),
      .rd_addr1 (rd_addr1),
      .rd_addr2 (rd_addr2),
      .rd_data1 (rd_data1),
      .rd_data2 (rd_data2)
   );

   brf_output_stage u_output_stage (
      .clock       (clock),
      .reset       (reset),
      .issue_en    (accept),
      .issue       (issue),
      .rd_data1    (rd_data1),
      .rd_data2    (rd_data2),
      .stage_ready (stage_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
